[hdl/wcm_pkg.sv]
// shared types, constants and helper functions for the wildcard pattern match counter
package wcm_pkg;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_WILDCARD_ON    = 3'd3,
      CSR_IGNORE_CASE    = 3'd4,
      CSR_WHOLE_WORD     = 3'd5,
      CSR_NO_LINE_SPAN   = 3'd6,
      CSR_NON_OVERLAP    = 3'd7
   } wcm_csr_index_type;

   // result kinds
   localparam logic RESULT_MATCH   = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A   = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'd122;
   localparam logic [7:0] CASE_DISTANCE  = 8'd32;
   localparam logic [7:0] CHAR_UNDERLINE = 8'd95;
   localparam logic [7:0] CHAR_WILDCARD  = 8'd63;
   localparam logic [7:0] CHAR_LF        = 8'd10;
   localparam logic [7:0] CHAR_CR        = 8'd13;

   // pattern bytes held in the two pattern registers
   localparam int PATTERN_BYTES = 16;
   localparam int PLEN_W        = 5;
   localparam int WORD_W        = 32;

   // event queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration as seen by the search logic
   typedef struct packed {
      logic [8*PATTERN_BYTES-1:0] pattern;
      logic [PLEN_W-1:0]          pattern_length;
      logic                       wildcard_on;
      logic                       ignore_case;
      logic                       whole_word;
      logic                       no_line_span;
      logic                       non_overlap;
   } wcm_cfg_type;

   // one classified byte: the results it causes
   typedef struct packed {
      logic              pend_conf;
      logic [WORD_W-1:0] pend_start;
      logic              cur_conf;
      logic [WORD_W-1:0] cur_start;
      logic              last;
   } wcm_event_type;

   // queue status towards front and back
   typedef struct packed {
      logic full;
      logic empty;
   } wcm_queue_status_type;

   // letter or underline
   function automatic logic is_word(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) || (c == CHAR_UNDERLINE);
   endfunction

   // ascii letter to the opposite case, other bytes unchanged
   function automatic logic [7:0] flip_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c + CASE_DISTANCE;
      else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) r = c - CASE_DISTANCE;
      return r;
   endfunction

endpackage

[hdl/wcm_csr.sv]
// configuration register file of the pattern match counter
module wcm_csr import wcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output wcm_cfg_type cfg
);

   wcm_cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (wcm_csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    cfg_in.pattern[63:0]   = csr_wdata;
            CSR_PATTERN_HIGH:   cfg_in.pattern[127:64] = csr_wdata;
            CSR_PATTERN_LENGTH: cfg_in.pattern_length  = csr_wdata[PLEN_W-1:0];
            CSR_WILDCARD_ON:    cfg_in.wildcard_on     = csr_wdata[0];
            CSR_IGNORE_CASE:    cfg_in.ignore_case     = csr_wdata[0];
            CSR_WHOLE_WORD:     cfg_in.whole_word      = csr_wdata[0];
            CSR_NO_LINE_SPAN:   cfg_in.no_line_span    = csr_wdata[0];
            CSR_NON_OVERLAP:    cfg_in.non_overlap     = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pattern_length: PLEN_W'(1), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/wcm_front.sv]
// front end: byte window, parallel pattern compare and match classification
module wcm_front import wcm_pkg::*; #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wcm_cfg_type          cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  wcm_queue_status_type q_status,
   output logic                 ev_push,
   output wcm_event_type        ev
);

   localparam int HIST_DEPTH = PATTERN_MAX + 1;
   localparam int LEN_W      = $clog2(PATTERN_MAX + 1);
   localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

   logic [7:0]        win_ff [HIST_DEPTH];
   logic [7:0]        win_in [HIST_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in, fill_next;
   logic [WORD_W-1:0] offset_ff, offset_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [WORD_W-1:0] pend_start_ff, pend_start_in;
   logic [WORD_W-1:0] nas_ff, nas_in;

   logic                   accept;
   logic [LEN_W-1:0]       len, len_m1;
   logic [WORD_W-1:0]      start_pos, nas_eff;
   logic                   pend_conf, bound_ok, before_ok, match, cur_conf, new_pend;
   logic [PATTERN_MAX-1:0] pos_ok;

   assign accept    = req_valid && !q_status.full;
   assign req_ready = !q_status.full;

   // effective pattern length, clamped to one and to the window
   always_comb begin
      if (cfg.pattern_length == '0) len = LEN_W'(1);
      else if (32'(cfg.pattern_length) > 32'(PATTERN_MAX)) len = LEN_W'(PATTERN_MAX);
      else len = LEN_W'(cfg.pattern_length);
   end
   assign len_m1 = len - LEN_W'(1);

   // window after this byte is shifted in
   always_comb begin
      win_in[0] = req_data_byte;
      for (int k = 1; k < HIST_DEPTH; k++) win_in[k] = win_ff[k-1];
   end
   assign fill_next = (fill_ff < FILL_W'(HIST_DEPTH)) ? fill_ff + FILL_W'(1) : fill_ff;

   // pending whole-word match is settled by this byte
   assign pend_conf = pend_valid_ff && !is_word(req_data_byte);

   // non-overlap bound, moved on by a pending match confirmed at this byte
   assign start_pos = offset_ff - WORD_W'(len_m1);
   assign nas_eff   = pend_conf ? pend_start_ff + WORD_W'(len) : nas_ff;
   assign bound_ok  = !cfg.non_overlap || (start_pos >= nas_eff);

   // one comparator per pattern byte
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
      logic [7:0] dk, pk;
      logic       hit, line_ok;
      if (i < PATTERN_BYTES) begin : g_pat
         assign pk = cfg.pattern[8*i +: 8];
      end else begin : g_zero
         assign pk = '0;
      end
      assign dk      = win_in[len_m1 - LEN_W'(i)];
      assign hit     = (dk == pk) || (cfg.wildcard_on && pk == CHAR_WILDCARD) ||
                       (cfg.ignore_case && dk == flip_case(pk));
      assign line_ok = !(cfg.no_line_span && (dk == CHAR_LF || dk == CHAR_CR));
      assign pos_ok[i] = !(LEN_W'(i) < len) || (hit && line_ok);
   end

   // word boundary in front of the candidate
   assign before_ok = !(cfg.whole_word && fill_next > FILL_W'(len) && is_word(win_in[len]));

   assign match    = (fill_next >= FILL_W'(len)) && (&pos_ok) && bound_ok && before_ok;
   assign new_pend = match && cfg.whole_word && !req_last_byte;
   assign cur_conf = match && !new_pend;

   // event towards the back end
   always_comb begin
      ev.pend_conf  = pend_conf;
      ev.pend_start = pend_start_ff;
      ev.cur_conf   = cur_conf;
      ev.cur_start  = start_pos;
      ev.last       = req_last_byte;
   end
   assign ev_push = accept && (pend_conf || cur_conf || req_last_byte);

   // stream state update, cleared at end of stream
   always_comb begin
      fill_in       = fill_next;
      offset_in     = offset_ff + WORD_W'(1);
      pend_valid_in = new_pend;
      pend_start_in = new_pend ? start_pos : pend_start_ff;
      nas_in        = cur_conf ? start_pos + WORD_W'(len) : nas_eff;
      if (req_last_byte) begin
         fill_in       = '0;
         offset_in     = '0;
         pend_valid_in = 1'b0;
         nas_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         offset_ff     <= '0;
         pend_valid_ff <= 1'b0;
         nas_ff        <= '0;
      end else if (accept) begin
         fill_ff       <= fill_in;
         offset_ff     <= offset_in;
         pend_valid_ff <= pend_valid_in;
         nas_ff        <= nas_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff        <= win_in;
         pend_start_ff <= pend_start_in;
      end
   end

endmodule

[hdl/wcm_queue.sv]
// short event queue between front and back end
module wcm_queue import wcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wcm_event_type        push_data,
   input  logic                 pop,
   output wcm_event_type        head,
   output wcm_queue_status_type status
);

   wcm_event_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (push && !pop) count_ff <= count_ff + QCNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - QCNT_W'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[hdl/wcm_back.sv]
// back end: match counter and one result word per cycle, while the output is free, from each event
module wcm_back import wcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  wcm_event_type        q_head,
   input  wcm_queue_status_type q_status,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_result_kind,
   output logic [WORD_W-1:0]    rsp_match_start,
   output logic [WORD_W-1:0]    rsp_match_total,
   output logic                 rsp_last_result
);

   logic              work_valid_ff;
   wcm_event_type     work_ff, work_rem;
   logic [WORD_W-1:0] count_ff, count_inc;
   logic              rsp_valid_ff;
   logic              kind_ff, last_ff;
   logic [WORD_W-1:0] start_ff, total_ff;

   logic              out_free, emit, work_done;
   logic              sel_kind;
   logic [WORD_W-1:0] sel_start, sel_total;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = work_valid_ff && out_free;
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + WORD_W'(1);

   // pick the first outstanding result of the event in hand
   always_comb begin
      work_rem  = work_ff;
      sel_kind  = RESULT_SUMMARY;
      sel_start = '0;
      sel_total = count_ff;
      if (work_ff.pend_conf) begin
         sel_kind           = RESULT_MATCH;
         sel_start          = work_ff.pend_start;
         sel_total          = count_inc;
         work_rem.pend_conf = 1'b0;
      end else if (work_ff.cur_conf) begin
         sel_kind          = RESULT_MATCH;
         sel_start         = work_ff.cur_start;
         sel_total         = count_inc;
         work_rem.cur_conf = 1'b0;
      end else begin
         work_rem.last = 1'b0;
      end
   end
   assign work_done = !(work_rem.pend_conf || work_rem.cur_conf || work_rem.last);

   assign q_pop = !q_status.empty && (!work_valid_ff || (emit && work_done));

   // event in hand
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else if (q_pop) begin
         work_valid_ff <= 1'b1;
      end else if (emit && work_done) begin
         work_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) work_ff <= q_head;
      else if (emit) work_ff <= work_rem;
   end

   // running match total
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (emit && sel_kind == RESULT_MATCH) begin
         count_ff <= count_inc;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= sel_kind;
         start_ff <= sel_start;
         total_ff <= sel_total;
         last_ff  <= work_done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_match_start = start_ff;
   assign rsp_match_total = total_ff;
   assign rsp_last_result = last_ff;

endmodule

[hdl/wildcard_pattern_match_counter_top.sv]
// top level of the wildcard pattern match counter
// Searches a byte stream for a configured pattern of up to PATTERN_MAX bytes (bytes past the
// sixteenth read as zero) with wildcard, case folding, whole word, no line span and
// non-overlap options. One byte is accepted per clock while the four-entry event queue between
// the compare front end and the result back end has room; the whole pattern is compared in
// parallel against a shift window in that same cycle. The back end sends one result word per
// clock while the result port is ready, so a byte that causes two or three results (settled
// whole-word match, new match, end-of-stream summary) takes one output word each, and the
// queue absorbs such bursts. A byte's first result passes through the event queue, the back
// end's event register and its output register. Configuration registers take effect at the
// next byte and are to be written only when the block is idle; the block does not enforce it.
module wildcard_pattern_match_counter_top import wcm_pkg::*; #(
   parameter int PATTERN_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_match_start,
   output logic [31:0] rsp_match_total,
   output logic        rsp_last_result
);

   wcm_cfg_type          cfg;
   wcm_event_type        ev, q_head;
   wcm_queue_status_type q_status;
   logic                 ev_push, q_pop;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   wcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wcm_front #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .ev_push       (ev_push),
      .ev            (ev)
   );

   wcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   wcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_match_start (rsp_match_start),
      .rsp_match_total (rsp_match_total),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTHESIS
   // a summary is always the final word of its byte
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_SUMMARY |-> rsp_last_result)
      else $error("summary word not marked as last");

   // a summary carries no start offset
   a_summary_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_SUMMARY |-> rsp_match_start == '0)
      else $error("summary word with non-zero start");

   // a confirmed match has been counted
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_MATCH |-> rsp_match_total != '0)
      else $error("match word with zero total");

   // the front end never pushes into a full queue
   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      ev_push |-> !q_status.full)
      else $error("event pushed into full queue");
`endif

endmodule

[sim/wildcard_pattern_match_counter_checker.sv]
// checker for the wildcard pattern match counter: mirrors the search, compares every result word
module wildcard_pattern_match_counter_checker import wcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_result_kind,
   input  logic [31:0] rsp_match_start,
   input  logic [31:0] rsp_match_total,
   input  logic        rsp_last_result,
   output int          words_owed,
   output int          words_checked,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PATTERN_MAX = 16;
   localparam int WINDOW_DEPTH = PATTERN_MAX + 1;
   localparam int PRINT_CAP = 100;

   // one result word as the block should send it
   typedef struct {
      logic        kind;
      logic [31:0] start;
      logic [31:0] total;
      logic        last;
   } search_word_type;

   search_word_type owed_words[$];
   search_word_type made[3];
   int              made_n;
   int              mismatches = 0;
   int              checked_n = 0;

   // search setting as written over the register port
   logic [127:0] pat;
   logic [4:0]   pat_len;
   logic         wild, fold, word_only, single_line, disjoint;

   // stream state
   logic [7:0]   window[WINDOW_DEPTH];
   int           fill;
   logic [31:0]  offset, total, held_start, resume_at;
   logic         held;

   assign fail_count    = mismatches;
   assign words_checked = checked_n;

   function automatic logic letter_or_underline(input logic [7:0] c);
      return (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]}) ||
             (c == CHAR_UNDERLINE);
   endfunction

   function automatic logic [7:0] other_case(input logic [7:0] c);
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         return c ^ CASE_DISTANCE;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   task automatic clear_stream();
      int i;
      for (i = 0; i < WINDOW_DEPTH; i++) window[i] = 8'd0;
      fill       = 0;
      offset     = '0;
      held       = 1'b0;
      held_start = '0;
      resume_at  = '0;
   endtask

   task automatic reset_model();
      pat         = '0;
      pat_len     = 5'd1;
      wild        = 1'b0;
      fold        = 1'b0;
      word_only   = 1'b0;
      single_line = 1'b0;
      disjoint    = 1'b0;
      total       = '0;
      clear_stream();
      owed_words.delete();
   endtask

   task automatic write_setting(input logic [2:0] idx, input logic [63:0] v);
      case (wcm_csr_index_type'(idx))
         CSR_PATTERN_LOW:    pat[63:0]   = v;
         CSR_PATTERN_HIGH:   pat[127:64] = v;
         CSR_PATTERN_LENGTH: pat_len     = v[4:0];
         CSR_WILDCARD_ON:    wild        = v[0];
         CSR_IGNORE_CASE:    fold        = v[0];
         CSR_WHOLE_WORD:     word_only   = v[0];
         CSR_NO_LINE_SPAN:   single_line = v[0];
         CSR_NON_OVERLAP:    disjoint    = v[0];
         default:            ;
      endcase
   endtask

   // count a match, move the non-overlap bound past it and queue its word
   task automatic confirm_match(input logic [31:0] s, input int len);
      if (total != '1) total++;
      resume_at = s + 32'(len);
      made[made_n] = '{RESULT_MATCH, s, total, 1'b0};
      made_n++;
   endtask

   // one byte through the search: work out the words it causes
   task automatic scan_byte(input logic [7:0] d, input logic fin);
      int          i, len;
      logic [31:0] s;
      logic        ok, hit;
      logic [7:0]  pk, dk;
      made_n = 0;
      len = (pat_len == 0) ? 1 : ((pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len));

      // shift the window
      for (i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = d;
      if (fill < WINDOW_DEPTH) fill++;

      // a held whole-word match stands unless a word character follows
      if (held) begin
         held = 1'b0;
         if (!letter_or_underline(d)) confirm_match(held_start, len);
      end

      // candidate ending at this byte
      if (fill >= len) begin
         s  = offset - 32'(len - 1);
         ok = !disjoint || (s >= resume_at);
         for (i = 0; ok && i < len; i++) begin
            pk  = pat[8*i +: 8];
            dk  = window[len-1-i];
            hit = (dk == pk) || (wild && pk == CHAR_WILDCARD) || (fold && dk == other_case(pk));
            if (!hit) ok = 1'b0;
            if (single_line && (dk == CHAR_LF || dk == CHAR_CR)) ok = 1'b0;
         end
         if (ok && word_only && fill > len && letter_or_underline(window[len])) ok = 1'b0;
         if (ok) begin
            if (word_only && !fin) begin
               held       = 1'b1;
               held_start = s;
            end else begin
               confirm_match(s, len);
            end
         end
      end

      offset++;

      // end of stream: summary, then a fresh stream
      if (fin) begin
         made[made_n] = '{RESULT_SUMMARY, 32'd0, total, 1'b0};
         made_n++;
         clear_stream();
      end
      if (made_n > 0) made[made_n-1].last = 1'b1;
      for (i = 0; i < made_n; i++) owed_words.push_back(made[i]);
   endtask

   task automatic check_word();
      search_word_type want;
      checked_n++;
      if (owed_words.size() == 0) begin
         report_mismatch("word with nothing owed, match_start", rsp_match_start, 32'd0);
      end else begin
         want = owed_words.pop_front();
         if (rsp_result_kind !== want.kind)
            report_mismatch("result_kind", 32'(rsp_result_kind), 32'(want.kind));
         if (rsp_match_start !== want.start)
            report_mismatch("match_start", rsp_match_start, want.start);
         if (rsp_match_total !== want.total)
            report_mismatch("match_total", rsp_match_total, want.total);
         if (rsp_last_result !== want.last)
            report_mismatch("last_result", 32'(rsp_last_result), 32'(want.last));
      end
   endtask

   // watch the three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_valid && csr_ready) write_setting(csr_index, csr_wdata);
         if (req_valid && req_ready) scan_byte(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) check_word();
      end
      words_owed <= owed_words.size();
   end

endmodule

[sim/wildcard_pattern_match_counter_top_test.sv]
// testbench top for the wildcard pattern match counter: stimulus, idling and verdict
module wildcard_pattern_match_counter_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wcm_pkg::*;

   localparam int QUIET_CYCLES = 12;
   localparam int PHASES       = 8;
   localparam int PHASE_BYTES  = 16;
   localparam int PICK_LENGTH  = -1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [31:0] rsp_match_start;
   logic [31:0] rsp_match_total;
   logic        rsp_last_result;

   int words_owed, words_checked, fail_count;

   // setting last written, kept to shape the byte streams
   logic [127:0] cfg_pattern;
   logic [4:0]   cfg_len;
   logic         cfg_wild, cfg_fold, cfg_word, cfg_line, cfg_disjoint;

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int bytes_sent = 0;
   int streams_sent = 0;
   int settings_used = 0;

   wildcard_pattern_match_counter_top dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_match_start (rsp_match_start),
      .rsp_match_total (rsp_match_total),
      .rsp_last_result (rsp_last_result)
   );

   wildcard_pattern_match_counter_checker search_check (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_match_start (rsp_match_start),
      .rsp_match_total (rsp_match_total),
      .rsp_last_result (rsp_last_result),
      .words_owed      (words_owed),
      .words_checked   (words_checked),
      .fail_count      (fail_count)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // run limit
   initial begin
      #400000;
      $display("timeout with %0d result words still owed", words_owed);
      $display("[wildcard_pattern_match_counter_top] ERROR");
      $finish;
   end

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
   endfunction

   // pattern bytes drawn so that wildcards, letters, boundaries and line ends all turn up
   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(9))
         0:       return CHAR_WILDCARD;
         1, 2:    return CHAR_LOWER_A + 8'($urandom_range(2));
         3, 4:    return CHAR_UPPER_A + 8'($urandom_range(2));
         5:       return CHAR_UNDERLINE;
         6:       return 8'h20;
         7:       return $urandom_range(1) ? CHAR_LF : CHAR_CR;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_noise_byte();
      case ($urandom_range(7))
         0:       return 8'h20;
         1:       return CHAR_UNDERLINE;
         2:       return CHAR_LOWER_A + 8'($urandom_range(2));
         3:       return CHAR_UPPER_A + 8'($urandom_range(2));
         4:       return $urandom_range(1) ? CHAR_LF : CHAR_CR;
         5:       return 8'h2E;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic write_reg(input wcm_csr_index_type idx, input logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting();
      write_reg(CSR_PATTERN_LOW, cfg_pattern[63:0]);
      write_reg(CSR_PATTERN_HIGH, cfg_pattern[127:64]);
      write_reg(CSR_PATTERN_LENGTH, {59'd0, cfg_len});
      write_reg(CSR_WILDCARD_ON, {63'd0, cfg_wild});
      write_reg(CSR_IGNORE_CASE, {63'd0, cfg_fold});
      write_reg(CSR_WHOLE_WORD, {63'd0, cfg_word});
      write_reg(CSR_NO_LINE_SPAN, {63'd0, cfg_line});
      write_reg(CSR_NON_OVERLAP, {63'd0, cfg_disjoint});
      settings_used++;
   endtask

   task automatic random_setting(input int fixed_len);
      int k;
      for (k = 0; k < 16; k++) cfg_pattern[8*k +: 8] = pick_pattern_byte();
      if (fixed_len >= 0) cfg_len = 5'(fixed_len);
      else if ($urandom_range(9) == 0) cfg_len = 5'($urandom_range(17, 30));
      else cfg_len = 5'($urandom_range(2, 6));
      cfg_wild     = 1'($urandom_range(1));
      cfg_fold     = 1'($urandom_range(1));
      cfg_word     = 1'($urandom_range(1));
      cfg_line     = 1'($urandom_range(1));
      cfg_disjoint = 1'($urandom_range(1));
   endtask

   // one byte word, with a random gap in front of it
   task automatic send_byte(input logic [7:0] d, input logic fin);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= fin;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (fin) streams_sent++;
   endtask

   // stop sending until every owed word is back and the block has gone quiet
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_owed != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // a stream mostly of pattern copies, mixed with boundary and noise bytes
   task automatic send_stream(input int target);
      logic [7:0] text[$];
      logic [7:0] b;
      int         eff, k, extra;
      eff = (cfg_len == 0) ? 1 : ((cfg_len > 16) ? 16 : int'(cfg_len));
      while (text.size() < target) begin
         if ($urandom_range(99) < 60) begin
            // copy varied only where the setting lets it still match, now and then corrupted
            for (k = 0; k < eff; k++) begin
               b = cfg_pattern[8*k +: 8];
               if (cfg_wild && b == CHAR_WILDCARD) b = pick_noise_byte();
               else if (cfg_fold && is_letter(b) && $urandom_range(1) == 1) b = b ^ CASE_DISTANCE;
               if ($urandom_range(99) < 4) b = 8'($urandom_range(255));
               text.push_back(b);
            end
         end else begin
            extra = $urandom_range(1, 3);
            for (k = 0; k < extra; k++) text.push_back(pick_noise_byte());
         end
      end
      for (k = 0; k < text.size(); k++) begin
         send_byte(text[k], k == text.size() - 1);
         if (k < text.size() - 1 && $urandom_range(99) < 2) drain_results();
      end
   endtask

   // stimulus
   initial begin
      string phrase;
      int    k, ph, phase_end, plen;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wildcard, case folding, whole word held then confirmed, rejected, closed by stream end
      cfg_pattern  = 128'h43_3F_61;
      cfg_len      = 5'd3;
      cfg_wild     = 1'b1;
      cfg_fold     = 1'b1;
      cfg_word     = 1'b1;
      cfg_line     = 1'b0;
      cfg_disjoint = 1'b1;
      apply_setting();
      phrase = "aXc a?cd aac";
      for (k = 0; k < phrase.len(); k++) begin
         send_byte(phrase[k], k == phrase.len() - 1);
         if (k == 3) drain_results();
      end
      drain_results();

      // length zero taken as one, line end rejected, extreme byte values
      cfg_pattern  = 128'h0A;
      cfg_len      = 5'd0;
      cfg_wild     = 1'b0;
      cfg_fold     = 1'b0;
      cfg_word     = 1'b0;
      cfg_line     = 1'b1;
      cfg_disjoint = 1'b0;
      apply_setting();
      send_byte(CHAR_LF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_LF, 1'b1);
      drain_results();

      // all-ones pattern, overlapping candidate refused
      cfg_pattern  = '1;
      cfg_len      = 5'd2;
      cfg_line     = 1'b0;
      cfg_disjoint = 1'b1;
      apply_setting();
      for (k = 0; k < 4; k++) send_byte(8'hFF, k == 3);
      drain_results();

      // random streams under four idling patterns and a fresh setting each phase
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 80; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 80; end
            default: begin sender_idle_pct = 31; stall_pct = 31; end
         endcase
         case (ph)
            0:       plen = 1;
            3:       plen = 0;
            4:       plen = 16;
            7:       plen = 31;
            default: plen = PICK_LENGTH;
         endcase
         random_setting(plen);
         apply_setting();
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) send_stream($urandom_range(1, 24));
         drain_results();
      end

      $display("covered %0d bytes in %0d streams over %0d pattern settings, four idling mixes",
               bytes_sent, streams_sent, settings_used);
      $display("%0d result words compared, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0 && words_owed == 0) begin
         $display("[wildcard_pattern_match_counter_top] OK");
      end else begin
         $display("[wildcard_pattern_match_counter_top] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/wcm_pkg.sv
hdl/wcm_csr.sv
hdl/wcm_front.sv
hdl/wcm_queue.sv
hdl/wcm_back.sv
hdl/wildcard_pattern_match_counter_top.sv
sim/wildcard_pattern_match_counter_checker.sv
sim/wildcard_pattern_match_counter_top_test.sv
